FILE: rtl/isort_pkg.sv
// Shared types for the insertion sort engine.
// No dependencies; imported by the cell and the top level.
`default_nettype none

package isort_pkg;

  typedef logic signed [31:0] data_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/isort_cell.sv
// One compare-and-shift cell of the sorting chain.
// Depends on isort_pkg for data_t and cell_ctl_t.
`default_nettype none

module isort_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  isort_pkg::cell_ctl_t  ctl_i,
  input  isort_pkg::data_t      value_i,
  input  isort_pkg::data_t      prev_value_i,
  input  logic                  prev_valid_i,
  input  logic                  prev_gt_i,
  input  isort_pkg::data_t      next_value_i,
  input  logic                  next_valid_i,
  output isort_pkg::data_t      value_o,
  output logic                  valid_o,
  output logic                  gt_o
);
  import isort_pkg::*;

  data_t value_q, value_d;
  logic  valid_q, valid_d;
  logic  take;

  assign gt_o = valid_q && (value_q > value_i);
  assign take = gt_o || (!valid_q && prev_valid_i);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctl_i.pop) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end else if (ctl_i.insert && take) begin
      value_d = prev_gt_i ? prev_value_i : value_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

FILE: rtl/insertion_sort_engine_top.sv
// Insertion sort engine: a chain of CAPACITY compare-and-shift cells.
// Values are inserted as they are taken; a last request sets the drain flag, and the set
// drains from the head via the output register, one result per cycle unless stalled.
// Throughput: one value per cycle while loading; no request is taken while a set drains.
// Reset: asynchronous, active low; empties the chain and clears overflow and drain state.
// Depends on isort_pkg and isort_cell.
`default_nettype none

module insertion_sort_engine_top #(
  parameter int CAPACITY = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  isort_pkg::data_t       s_axis_tdata_i,   // [31:0] value
  input  logic                   s_axis_tlast_i,   // last
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output isort_pkg::data_t       m_axis_tdata_o,   // [31:0] sorted_value
  output logic                   m_axis_tlast_o,   // final_res
  output logic                   m_axis_tuser_o    // overflow
);
  import isort_pkg::*;

  data_t     cell_value [CAPACITY];
  logic      cell_valid [CAPACITY];
  logic      cell_gt    [CAPACITY];
  cell_ctl_t ctl;

  logic  drain_q, ovf_q;
  logic  m_valid_q, m_last_q, m_user_q;
  data_t m_data_q;
  logic  accept, full, pop;

  assign full   = cell_valid[CAPACITY-1];
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign pop    = drain_q && (!m_valid_q || m_axis_tready_i);

  assign ctl.insert = accept && !full;
  assign ctl.pop    = pop;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t prev_value, next_value;
    logic  prev_valid, prev_gt, next_valid;

    if (i == 0) begin : g_head
      assign prev_value = '0;
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    isort_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .value_i      (s_axis_tdata_i),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .prev_gt_i    (prev_gt),
      .next_value_i (next_value),
      .next_valid_i (next_valid),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .gt_o         (cell_gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q   <= 1'b0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept && full) begin
        ovf_q <= 1'b1;
      end
      if (accept && s_axis_tlast_i) begin
        drain_q <= 1'b1;
      end
      if (pop) begin
        m_valid_q <= 1'b1;
        if (!cell_valid[1]) begin
          drain_q <= 1'b0;
          ovf_q   <= 1'b0;
        end
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // hold the result until the downstream side takes it
  always_ff @(posedge clk_i) begin
    if (pop) begin
      m_data_q <= cell_value[0];
      m_last_q <= !cell_valid[1];
      m_user_q <= ovf_q;
    end
  end

  assign s_axis_tready_o = !drain_q;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

`default_nettype wire

FILE: rtl/isort_checker.sv
// Port-level checks for the insertion sort engine, bound to the top level.
// Depends on isort_pkg and insertion_sort_engine_top.
`default_nettype none

module isort_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_o,
  input  logic              s_axis_tlast_i,
  input  logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  input  isort_pkg::data_t  m_axis_tdata_o,
  input  logic              m_axis_tlast_o
);

  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("request taken right after a last request");

  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> !s_axis_tready_o)
    else $error("input open in the middle of an output run");

  a_final_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o && m_axis_tlast_o) |-> s_axis_tready_o)
    else $error("input still closed while the final result waits");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind insertion_sort_engine_top isort_checker u_isort_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

FILE: verif/tb.sv
// Testbench for insertion_sort_engine_top: streams sets of signed values and
// checks every sorted result against a behavioural copy of the sorted store.
// Depends on isort_pkg and the engine RTL; needs nothing else.
`default_nettype none

module tb;
  import isort_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 450;
  localparam int IDLE_PCT    = 36;

  typedef struct {
    data_t val;
    logic  fin;
    logic  ovf;
  } sorted_word_t;

  logic  clk_i;
  logic  rst_ni;
  logic  s_axis_tvalid_i;
  logic  s_axis_tready_o;
  data_t s_axis_tdata_i;   // [31:0] value
  logic  s_axis_tlast_i;   // last
  logic  m_axis_tvalid_o;
  logic  m_axis_tready_i;
  data_t m_axis_tdata_o;   // [31:0] sorted_value
  logic  m_axis_tlast_o;   // final_res
  logic  m_axis_tuser_o;   // overflow

  sorted_word_t pending_words[$];
  data_t        held_vals[$];
  logic         set_dropped = 1'b0;
  int           mismatches  = 0;
  int           cycle_count = 0;
  int           sent_items  = 0;
  int           rx_hold_len = 0;
  bit           quiet_run   = 1'b0;

  insertion_sort_engine_top #(.CAPACITY(CAPACITY)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %08h, expected %08h (cycle %0d)",
             field, got, want, cycle_count);
    mismatches++;
  endtask

  // Insert below every strictly greater entry; on last, emit the store in order.
  task automatic sort_request(data_t v, logic is_last);
    int pos;
    int n;
    sorted_word_t w;
    if (held_vals.size() >= CAPACITY) begin
      set_dropped = 1'b1;
    end else begin
      pos = held_vals.size();
      while (pos > 0 && held_vals[pos-1] > v) pos--;
      held_vals.insert(pos, v);
    end
    if (is_last) begin
      n = held_vals.size();
      for (int k = 0; k < n; k++) begin
        w.val = held_vals[k];
        w.fin = (k == n - 1);
        w.ovf = set_dropped;
        pending_words.push_back(w);
      end
      held_vals.delete();
      set_dropped = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sort_request(s_axis_tdata_i, s_axis_tlast_i);
  end

  always @(posedge clk_i) begin
    sorted_word_t w;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result with nothing pending", m_axis_tdata_o, '0);
      end else begin
        w = pending_words.pop_front();
        if (m_axis_tdata_o !== w.val) report_mismatch("sorted_value", m_axis_tdata_o, w.val);
        if (m_axis_tlast_o !== w.fin)
          report_mismatch("final_res", 32'(m_axis_tlast_o), 32'(w.fin));
        if (m_axis_tuser_o !== w.ovf)
          report_mismatch("overflow", 32'(m_axis_tuser_o), 32'(w.ovf));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    int n;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_len > 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        m_axis_tready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_item(data_t v, logic is_last);
    while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    s_axis_tlast_i  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_items++;
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(9))
      0, 1:    return data_t'($urandom_range(8)) - 32'sd4;
      2:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return data_t'($urandom());
    endcase
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
  endtask

  task automatic test_single_sets();
    send_item(32'sh80000000, 1'b1);
    send_item(32'sh7fffffff, 1'b1);
    send_item(32'sd0, 1'b1);
  endtask

  task automatic test_extremes();
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh80000000, 1'b0);
    send_item(32'sh7fffffff, 1'b1);
  endtask

  task automatic test_order_and_ties();
    for (int i = 5; i >= 1; i--) send_item(data_t'(i), i == 1);
    for (int i = 0; i < 3; i++) send_item(32'sd7, i == 2);
  endtask

  // Fill the store exactly, then overrun it so the last three requests are dropped.
  task automatic test_full_store();
    quiet_run = 1'b1;
    for (int i = CAPACITY; i >= 1; i--) send_item(data_t'(i) - 32'sd32, i == 1);
    send_set(CAPACITY + 3);
    quiet_run = 1'b0;
  endtask

  // Hold the receiver while a set drains and the next set is offered.
  task automatic test_backpressure();
    rx_hold_len = 300;
    send_set(40);
    for (int i = 0; i < 20; i++) send_item(pick_value(), 1'b0);
    send_item(pick_value(), 1'b1);
  endtask

  task automatic test_random_sets();
    int r;
    int n;
    while (sent_items < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 80)      n = $urandom_range(12, 1);
      else if (r < 95) n = $urandom_range(CAPACITY, 13);
      else             n = $urandom_range(CAPACITY + 8, CAPACITY + 1);
      send_set(n);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_sets();
    test_extremes();
    test_order_and_ties();
    test_full_store();
    test_backpressure();
    test_random_sets();

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/isort_pkg.sv
rtl/isort_cell.sv
rtl/insertion_sort_engine_top.sv
rtl/isort_checker.sv
verif/tb.sv
